// ----- hdl/qpht_pkg.sv -----
// Shared types and constants for the quadratic-probe hash table.
`timescale 1ns / 1ps
package qpht_pkg;

  // Table geometry. TABLE_SIZE is a power of two, so a residue mod the size is
  // the low IDX_W bits of a value.
  localparam int TABLE_SIZE = 16;
  localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
  localparam int CNT_W      = $clog2(TABLE_SIZE + 1);

  // Field widths
  localparam int OP_W       = 2;
  localparam int KEY_W      = 31;
  localparam int STATUS_W   = 3;
  localparam int SLOT_W     = 4;
  localparam int COEFF_W    = 4;
  localparam int CFG_IDX_W  = 2;

  // Operation codes
  localparam logic [OP_W-1:0] OP_INSERT = 2'd0;
  localparam logic [OP_W-1:0] OP_DELETE = 2'd1;
  localparam logic [OP_W-1:0] OP_SEARCH = 2'd2;

  // Result status codes
  localparam logic [STATUS_W-1:0] STS_INSERTED = 3'd0;
  localparam logic [STATUS_W-1:0] STS_FULL     = 3'd1;
  localparam logic [STATUS_W-1:0] STS_DELETED  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_ABSENT   = 3'd3;
  localparam logic [STATUS_W-1:0] STS_FOUND    = 3'd4;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_LINEAR = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SQUARE = 2'd1;

  localparam logic [COEFF_W-1:0] LINEAR_RESET = 4'd1;
  localparam logic [COEFF_W-1:0] SQUARE_RESET = 4'd3;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } item_in_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
  } item_out_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic probe;
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic hit;
    logic exhausted;
  } dp_sts_t;

endpackage

// ----- hdl/quadratic_probe_hash_table.sv -----
// Top level: quadratic-probe hash table with config registers and result register.
//
//  Channel | Ports                                  | Beat
//  --------+----------------------------------------+---------------------------------
//  in      | in_valid, in_ready, in_data            | one request: op, key
//  out     | out_valid, out_ready, out_data         | one result: status, slot
//  cfg     | cfg_valid, cfg_ready, cfg_index, _data | one register write (0 lin, 1 sq)
//
// An input beat loads the probe start (key mod TABLE_SIZE, the low key bits), then
// one slot-memory read per probe through a single registered read port. A hit ends
// the probe walk early; a miss or a full table walks every probe.
// The result sits in an output register, so the next request is taken while it waits;
// a new result waits for that register to drain. Reset (rst_n, synchronous) clears all
// occupancy bits at once and restores linear_coeff 1 and square_coeff 3.
`timescale 1ns / 1ps
module quadratic_probe_hash_table (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  qpht_pkg::item_in_t               in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output qpht_pkg::item_out_t              out_data,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [qpht_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [qpht_pkg::COEFF_W-1:0]     cfg_data
);
  import qpht_pkg::*;

  logic [COEFF_W-1:0] lin_r;
  logic [COEFF_W-1:0] sq_r;
  logic               out_valid_r;
  item_out_t          out_data_r;

  dp_cmd_t   cmd;
  dp_sts_t   sts;
  item_out_t res;
  logic      emit;
  logic      out_free;

  // Config writes are always accepted; unknown indexes drop.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lin_r <= LINEAR_RESET;
      sq_r  <= SQUARE_RESET;
    end else if (cfg_valid) begin
      if (cfg_index == CFG_LINEAR) lin_r <= cfg_data;
      if (cfg_index == CFG_SQUARE) sq_r  <= cfg_data;
    end
  end

  // Output register frees when empty or when its beat goes out this cycle.
  assign out_free = ~out_valid_r | out_ready;

  qpht_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .out_free (out_free),
    .sts      (sts),
    .cmd      (cmd),
    .emit     (emit)
  );

  qpht_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .lin_coeff (lin_r),
    .sq_coeff  (sq_r),
    .cmd       (cmd),
    .sts       (sts),
    .res       (res)
  );

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_data_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ----- hdl/qpht_dp.sv -----
// Datapath: probe start, probe address stepping, slot memory and match logic.
`timescale 1ns / 1ps
module qpht_dp (
  input  logic                          clk,
  input  logic                          rst_n,
  input  qpht_pkg::item_in_t            in_data,
  input  logic [qpht_pkg::COEFF_W-1:0]  lin_coeff,
  input  logic [qpht_pkg::COEFF_W-1:0]  sq_coeff,
  input  qpht_pkg::dp_cmd_t             cmd,
  output qpht_pkg::dp_sts_t             sts,
  output qpht_pkg::item_out_t           res
);
  import qpht_pkg::*;

  localparam logic [IDX_W:0]   SIZE_EXT   = (IDX_W + 1)'(TABLE_SIZE);
  localparam logic [CNT_W-1:0] PROBE_LAST = CNT_W'(TABLE_SIZE);

  // Modular add of two residues
  function automatic logic [IDX_W-1:0] add_mod(input logic [IDX_W-1:0] a,
                                               input logic [IDX_W-1:0] b);
    logic [IDX_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (s >= SIZE_EXT) s = s - SIZE_EXT;
    return s[IDX_W-1:0];
  endfunction

  logic [OP_W-1:0]       op_r;
  logic [KEY_W-1:0]      key_r;
  logic [IDX_W-1:0]      pos_r;
  logic [IDX_W-1:0]      delta_r;
  logic [IDX_W-1:0]      step_r;
  logic [CNT_W-1:0]      cnt_r;
  logic [KEY_W-1:0]      rd_key_r;
  logic                  rd_vld_r;
  logic [IDX_W-1:0]      rd_addr_r;
  logic                  rd_live_r;
  logic [TABLE_SIZE-1:0] valid_r;
  item_out_t             res_r;

  logic [KEY_W-1:0] key_mem [TABLE_SIZE];

  logic [IDX_W-1:0] base_idx;
  logic [IDX_W-1:0] c1_idx;
  logic [IDX_W-1:0] c2_idx;
  logic             is_ins;
  logic             is_find;
  logic             hit;
  logic             exhausted;
  logic             issue;
  logic             commit;

  // Residues mod a power-of-two size are the low index bits
  assign base_idx  = in_data.key[IDX_W-1:0];
  assign c1_idx    = IDX_W'(lin_coeff);
  assign c2_idx    = IDX_W'(sq_coeff);
  assign is_ins    = (op_r == OP_INSERT);
  assign is_find   = (op_r == OP_DELETE) || (op_r == OP_SEARCH);
  assign hit       = rd_live_r & (is_ins ? ~rd_vld_r
                                         : (is_find & rd_vld_r & (rd_key_r == key_r)));
  assign exhausted = rd_live_r & ~hit & (cnt_r == PROBE_LAST);
  assign issue     = cmd.probe & (cnt_r != PROBE_LAST);
  assign commit    = cmd.probe & hit;

  assign sts.hit       = hit;
  assign sts.exhausted = exhausted;
  assign res           = res_r;

  // Request registers and probe stepping
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r    <= in_data.op;
      key_r   <= in_data.key;
      // p(0) = key mod N; p(i+1) - p(i) = c1 + c2*(2i+1)
      pos_r   <= base_idx;
      delta_r <= add_mod(c1_idx, c2_idx);
      step_r  <= add_mod(c2_idx, c2_idx);
    end else if (issue) begin
      pos_r   <= add_mod(pos_r, delta_r);
      delta_r <= add_mod(delta_r, step_r);
    end
    if (issue) begin
      rd_vld_r  <= valid_r[pos_r];
      rd_addr_r <= pos_r;
    end
    if (commit) begin
      res_r.slot <= SLOT_W'(rd_addr_r);
      priority if (is_ins)               res_r.status <= STS_INSERTED;
      else if (op_r == OP_DELETE)        res_r.status <= STS_DELETED;
      else                               res_r.status <= STS_FOUND;
    end else if (cmd.probe && exhausted) begin
      res_r.slot   <= '0;
      res_r.status <= is_ins ? STS_FULL : STS_ABSENT;
    end
  end

  // Probe count, read stage flag and occupancy bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r     <= '0;
      rd_live_r <= 1'b0;
      valid_r   <= '0;
    end else begin
      if (cmd.load) begin
        cnt_r     <= '0;
        rd_live_r <= 1'b0;
      end else if (cmd.probe) begin
        rd_live_r <= issue;
        if (issue) cnt_r <= cnt_r + 1'b1;
      end
      if (commit && is_ins) valid_r[rd_addr_r] <= 1'b1;
      else if (commit && (op_r == OP_DELETE)) valid_r[rd_addr_r] <= 1'b0;
    end
  end

  // Key store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (commit && is_ins) key_mem[rd_addr_r] <= key_r;
    if (issue) rd_key_r <= key_mem[pos_r];
  end

endmodule

// ----- hdl/qpht_ctrl.sv -----
// Controller: sequences load, probing and result handoff.
`timescale 1ns / 1ps
module qpht_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                out_free,
  input  qpht_pkg::dp_sts_t   sts,
  output qpht_pkg::dp_cmd_t   cmd,
  output logic                emit
);
  import qpht_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_PROBE,
    S_FINISH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PROBE;
      end
      S_PROBE: begin
        if (sts.hit || sts.exhausted) state_nxt = S_FINISH;
      end
      S_FINISH: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign cmd.load  = (state_r == S_IDLE) & in_valid;
  assign cmd.probe = (state_r == S_PROBE);
  assign emit      = (state_r == S_FINISH) & out_free;

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench for quadratic_probe_hash_table: random traffic, backpressure, scoreboard.
`timescale 1ns / 1ps
module tb_top;
  import qpht_pkg::*;

  // Codes the package leaves out: the spare op and the two unmapped register slots
  localparam logic [OP_W-1:0]      OP_UNUSED  = 2'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE3 = 2'd3;

  localparam logic [KEY_W-1:0] KEY_MAX = {KEY_W{1'b1}};

  // A full miss walks every probe; the drain covers one such request
  // plus the result register with margin.
  localparam int DRAIN_CYCLES   = TABLE_SIZE + 16;
  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  item_in_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  item_out_t out_data;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [COEFF_W-1:0]   cfg_data = '0;

  quadratic_probe_hash_table dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow table: our own copy of the slot store and the probe coefficients.
  // Keys are only ever compared where the occupancy bit is set, so the key
  // array needs no reset.
  // ---------------------------------------------------------------------------
  logic [KEY_W-1:0]   shadow_key [TABLE_SIZE];
  logic               shadow_used[TABLE_SIZE] = '{default: 1'b0};
  logic [COEFF_W-1:0] lin_coeff = LINEAR_RESET;
  logic [COEFF_W-1:0] sq_coeff  = SQUARE_RESET;

  item_in_t  pending_lookups[$];    // requests waiting for the driver
  item_out_t predicted_results[$];  // one entry per accepted request, in order
  logic [KEY_W-1:0] stored_keys[$]; // what the generator believes sits in the table

  int errors    = 0;
  int n_sent    = 0;
  int n_results = 0;

  // Walk the probe sequence for one request and apply it to the shadow table.
  // Empty slots never cut a delete or search short; probing stops only at a match.
  function automatic item_out_t apply_request(item_in_t req);
    item_out_t   res;
    int unsigned base;
    int unsigned p;
    res.status = STS_ABSENT;
    res.slot   = '0;
    base = req.key % TABLE_SIZE;
    case (req.op)
      OP_INSERT: begin
        res.status = STS_FULL;
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
          p = (base + lin_coeff * i + sq_coeff * i * i) % TABLE_SIZE;
          if (!shadow_used[p]) begin
            shadow_used[p] = 1'b1;
            shadow_key[p]  = req.key;
            res.status     = STS_INSERTED;
            res.slot       = p[SLOT_W-1:0];
            break;
          end
        end
      end
      OP_DELETE, OP_SEARCH: begin
        for (int unsigned i = 0; i < TABLE_SIZE; i++) begin
          p = (base + lin_coeff * i + sq_coeff * i * i) % TABLE_SIZE;
          if (shadow_used[p] && shadow_key[p] == req.key) begin
            if (req.op == OP_DELETE) begin
              shadow_used[p] = 1'b0;
              res.status     = STS_DELETED;
            end else begin
              res.status = STS_FOUND;
            end
            res.slot = p[SLOT_W-1:0];
            break;
          end
        end
      end
      default: ; // spare op code: table untouched, result stays "not present"
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [7:0] got,
                                 input logic [7:0] want);
    $display("[%0t] mismatch: %s got %0d expected %0d", $time, what, got, want);
    errors++;
  endtask

  // ---------------------------------------------------------------------------
  // Driver: offer one request beat at a time from pending_lookups. After each
  // accepted beat, draw an idle count; it only runs down on cycles where the
  // block is ready, so the gap really starves the block instead of hiding
  // behind its own probing time. Every fifth stretch of 60 beats sends back
  // to back.
  // ---------------------------------------------------------------------------
  int send_gap = 0;

  always @(posedge clk) begin
    logic next_valid;
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      next_valid = in_valid;
      if (in_valid && in_ready) begin
        // predict at the accepting edge, with the coefficients in force now
        predicted_results.push_back(apply_request(in_data));
        n_sent++;
        send_gap   = ((n_sent / 60) % 5 == 4) ? 0 : $urandom_range(0, 4);
        next_valid = 1'b0;
      end else if (!in_valid && send_gap > 0 && in_ready) begin
        send_gap--;
      end
      if (!next_valid && send_gap == 0 && pending_lookups.size() > 0) begin
        in_data    <= pending_lookups.pop_front();
        next_valid = 1'b1;
      end
      // single assignment per edge, so a back-to-back beat keeps valid high
      in_valid <= next_valid;
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result beat against the oldest prediction, then draw
  // how long to stall the next one. The stall counts down only while a result
  // is actually presented. Twice in the run, hold off for HOLD_CYCLES so the
  // result register and the request behind it back up into in_ready.
  // ---------------------------------------------------------------------------
  int rx_wait   = 0;
  int hold_left = 0;

  always @(posedge clk) begin
    item_out_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   = 0;
      hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (predicted_results.size() == 0) begin
          report_mismatch("result with nothing pending, status", 8'(out_data.status), 8'd0);
        end else begin
          want = predicted_results.pop_front();
          if (out_data.status !== want.status)
            report_mismatch("status", 8'(out_data.status), 8'(want.status));
          if (out_data.slot !== want.slot)
            report_mismatch("slot", 8'(out_data.slot), 8'(want.slot));
        end
        n_results++;
        rx_wait = ((n_results / 70) % 4 == 1) ? 0 : $urandom_range(0, 4);
        if (n_results == 300 || n_results == 1000)
          hold_left = HOLD_CYCLES;
      end else if (hold_left > 0) begin
        hold_left--;
      end else if (out_valid && rx_wait > 0) begin
        rx_wait--;
      end
      out_ready <= (hold_left == 0 && rx_wait == 0);
    end
  end

  // Watchdog: any beat on any channel resets the idle count.
  int idle_cycles = 0;

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("[%0t] watchdog: no beat for %0d cycles", $time, idle_cycles);
        $display("FAIL");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Queue one request and keep the generator's view of the table in step.
  task automatic queue_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] key);
    item_in_t req;
    req.op  = op;
    req.key = key;
    pending_lookups.push_back(req);
    if (op == OP_INSERT) begin
      stored_keys.push_back(key);
    end else if (op == OP_DELETE) begin
      for (int j = 0; j < stored_keys.size(); j++) begin
        if (stored_keys[j] == key) begin
          stored_keys.delete(j);
          break;
        end
      end
    end
  endtask

  // Delete every stored copy so the next coefficient setting starts empty;
  // entries placed under old coefficients could otherwise become unreachable.
  task automatic purge_stored();
    while (stored_keys.size() > 0)
      queue_req(OP_DELETE, stored_keys[0]);
  endtask

  // Mostly well-formed traffic: inserts, then deletes and searches of keys that
  // are in the table, with a share of misses, duplicates, colliding keys and
  // spare op codes. The insert share follows the table fill, so it swings
  // between near empty and full.
  task automatic add_random_request(input int cluster);
    logic [KEY_W-1:0] key;
    int pick;
    int ins_w;
    int pool_n;
    pool_n = stored_keys.size();
    ins_w  = (pool_n > 18) ? 20 : (pool_n < 4) ? 70 : 40;
    pick   = $urandom_range(0, 99);
    key    = KEY_W'($urandom);
    if (pick < 5) begin
      queue_req(OP_UNUSED, key);
    end else if (pick < 5 + ins_w) begin
      case ($urandom_range(0, 9))
        0, 1: if (pool_n > 0) key = stored_keys[$urandom_range(0, pool_n - 1)];
        2, 3, 4: key[IDX_W-1:0] = cluster[IDX_W-1:0];
        5: key = $urandom_range(0, 1) ? KEY_MAX : {KEY_W{1'b0}};
        default: ;
      endcase
      queue_req(OP_INSERT, key);
    end else begin
      if (pool_n > 0 && $urandom_range(0, 4) != 0)
        key = stored_keys[$urandom_range(0, pool_n - 1)];
      queue_req(($urandom_range(0, 9) < 4) ? OP_DELETE : OP_SEARCH, key);
    end
  endtask

  // Wait until every request is sent and answered, then let the block settle.
  task automatic settle();
    while (pending_lookups.size() != 0 || in_valid || predicted_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // One register beat. Valid stays high into the next call unless this is the
  // last write of the group. Called on a rising edge.
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [COEFF_W-1:0] val,
                           input logic last);
    cfg_index <= idx;
    cfg_data  <= val;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_LINEAR: lin_coeff = val;
      CFG_SQUARE: sq_coeff  = val;
      default: ; // unmapped slot: write is dropped
    endcase
    if (last)
      cfg_valid <= 1'b0;
  endtask

  // Directed opening at the reset coefficients (1, 3): empty-table misses, key
  // extremes, the spare op, duplicates, and a colliding run that overflows the
  // eight slots that residue 5 can reach, ending in table-full results.
  task automatic queue_directed();
    queue_req(OP_SEARCH, {KEY_W{1'b0}});
    queue_req(OP_DELETE, KEY_MAX);
    queue_req(OP_INSERT, {KEY_W{1'b0}});
    queue_req(OP_INSERT, KEY_MAX);
    queue_req(OP_SEARCH, KEY_MAX);
    queue_req(OP_SEARCH, {KEY_W{1'b0}});
    queue_req(OP_INSERT, 31'h5555_5555);
    queue_req(OP_INSERT, 31'h2AAA_AAAA);
    queue_req(OP_UNUSED, KEY_MAX);
    queue_req(OP_INSERT, {KEY_W{1'b0}});
    queue_req(OP_DELETE, {KEY_W{1'b0}});
    queue_req(OP_SEARCH, {KEY_W{1'b0}});
    queue_req(OP_DELETE, {KEY_W{1'b0}});
    queue_req(OP_DELETE, {KEY_W{1'b0}});
    for (int k = 0; k < 9; k++)
      queue_req(OP_INSERT, KEY_W'(k * 32'h0800_0010 + 5));
    queue_req(OP_SEARCH, KEY_W'(8 * 32'h0800_0010 + 5));
    queue_req(OP_UNUSED, {KEY_W{1'b0}});
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence: reset, directed run, then phases of random traffic, each
  // under its own coefficient pair written while the block is idle.
  // ---------------------------------------------------------------------------
  initial begin : stimulus
    logic [COEFF_W-1:0] lin;
    logic [COEFF_W-1:0] sq;
    int cluster;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    queue_directed();
    purge_stored();
    for (int ph = 0; ph < 10; ph++) begin
      case (ph)
        0: begin lin = 4'd0;  sq = 4'd0;  end
        1: begin lin = 4'd15; sq = 4'd15; end
        2: begin lin = 4'd1;  sq = 4'd0;  end
        3: begin lin = 4'd0;  sq = 4'd1;  end
        4: begin lin = 4'd15; sq = 4'd0;  end
        5: begin lin = 4'd0;  sq = 4'd15; end
        6: begin lin = LINEAR_RESET; sq = SQUARE_RESET; end
        default: begin
          lin = COEFF_W'($urandom);
          sq  = COEFF_W'($urandom);
        end
      endcase
      settle();
      cfg_write(CFG_LINEAR, lin, 1'b0);
      cfg_write(ph[0] ? CFG_SPARE3 : CFG_SPARE2, COEFF_W'($urandom), 1'b0);
      cfg_write(CFG_SQUARE, sq, 1'b1);
      @(negedge clk);
      cluster = $urandom_range(0, TABLE_SIZE - 1);
      repeat (150) add_random_request(cluster);
      purge_stored();
    end
    settle();
    @(negedge clk);
    if (errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// ----- sim.f -----
hdl/qpht_pkg.sv
hdl/qpht_dp.sv
hdl/qpht_ctrl.sv
hdl/quadratic_probe_hash_table.sv
tb/tb_top.sv
